// File: src/sapq_pkg.sv
`timescale 1ns / 1ps

package sapq_pkg;

  // Field widths fixed by the interface
  localparam int ValW  = 32;
  localparam int PrioW = 16;
  localparam int CfgW  = 7;

  // Default number of cells and capacity after reset
  localparam int             DefaultDepth = 64;
  localparam logic [CfgW-1:0] CapReset    = 7'd64;

  // Command kinds
  localparam logic KindInsert = 1'b0;
  localparam logic KindRemove = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } sapq_status_e;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } sapq_ctrl_t;

endpackage

// File: src/sapq_cell.sv
`timescale 1ns / 1ps

module sapq_cell (
  input  logic                               clk_i,
  input  sapq_pkg::sapq_ctrl_t               ctrl_i,
  input  logic                               occ_i,
  input  logic signed [sapq_pkg::ValW-1:0]   new_val_i,
  input  logic        [sapq_pkg::PrioW-1:0]  new_prio_i,
  input  logic                               left_keep_i,
  input  logic signed [sapq_pkg::ValW-1:0]   left_val_i,
  input  logic        [sapq_pkg::PrioW-1:0]  left_prio_i,
  input  logic signed [sapq_pkg::ValW-1:0]   right_val_i,
  input  logic        [sapq_pkg::PrioW-1:0]  right_prio_i,
  output logic                               keep_o,
  output logic signed [sapq_pkg::ValW-1:0]   val_o,
  output logic        [sapq_pkg::PrioW-1:0]  prio_o
);
  import sapq_pkg::*;

  logic signed [ValW-1:0]  val_q, val_d;
  logic        [PrioW-1:0] prio_q, prio_d;

  // An occupied cell with strictly higher priority stays put on insert
  assign keep_o = occ_i && (prio_q > new_prio_i);

  // Insert: hold, take the new entry, or take the left neighbour.
  // Remove: take the right neighbour.
  always_comb begin
    val_d  = val_q;
    prio_d = prio_q;
    if (ctrl_i.ins) begin
      if (!keep_o) begin
        if (left_keep_i) begin
          val_d  = new_val_i;
          prio_d = new_prio_i;
        end else begin
          val_d  = left_val_i;
          prio_d = left_prio_i;
        end
      end
    end else if (ctrl_i.rem) begin
      val_d  = right_val_i;
      prio_d = right_prio_i;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    prio_q <= prio_d;
  end

  assign val_o  = val_q;
  assign prio_o = prio_q;

endmodule

// File: src/sorted_array_priority_queue.sv
`timescale 1ns / 1ps

// Priority queue built as a row of cells kept sorted by descending priority.
// Command channel: a command is taken at a rising edge where start is high
// and busy is low; busy stays low, so a command may be issued every cycle.
// kind_i selects insert (value and priority) or remove of the front entry.
// Result channel: in the cycle after each command, result_valid_o is high for
// exactly one cycle with status_o, out_value_o, out_prio_o and fill_count_o.
// Throughput is one command per cycle: every cell compares its priority
// with the incoming one and shifts in the same cycle.
// The receiver cannot stall; a result not taken in its cycle is gone.
// Configuration: one capacity register, written by a cfg_valid_i/cfg_ready_o
// transfer; cfg_ready_o is always high. Write only while no command is in
// flight. Capacities above DEPTH act as DEPTH; zero refuses every insert.
// Reset empties the queue and sets capacity to 64; cell contents are not
// cleared, since only cells below the fill count are ever read.
module sorted_array_priority_queue #(
  parameter int DEPTH = sapq_pkg::DefaultDepth,
  parameter int CntW  = $clog2(DEPTH + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              kind_i,
  input  logic signed [sapq_pkg::ValW-1:0]  item_value_i,
  input  logic        [sapq_pkg::PrioW-1:0] prio_in_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic        [sapq_pkg::CfgW-1:0]  cfg_data_i,
  output logic                              result_valid_o,
  output logic        [1:0]                 status_o,
  output logic signed [sapq_pkg::ValW-1:0]  out_value_o,
  output logic        [sapq_pkg::PrioW-1:0] out_prio_o,
  output logic        [CntW-1:0]            fill_count_o
);
  import sapq_pkg::*;

  localparam int CmpW = (CntW > CfgW) ? CntW : CfgW;

  logic                   accept;
  logic                   full;
  sapq_ctrl_t             ctrl;
  logic [CfgW-1:0]        capacity_q;
  logic [CntW-1:0]        count_q, count_d;
  logic                   res_valid_q;
  sapq_status_e           status_q, status_d;
  logic signed [ValW-1:0] res_val_q, res_val_d;
  logic [PrioW-1:0]       res_prio_q, res_prio_d;

  logic signed [ValW-1:0] cell_val  [DEPTH];
  logic [PrioW-1:0]       cell_prio [DEPTH];
  logic                   cell_keep [DEPTH];

  // Commands are never held off
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // Full against the capacity saturated to the number of cells
  assign full = (CmpW'(count_q) >= CmpW'(capacity_q)) || (count_q >= CntW'(DEPTH));

  // Command decode
  always_comb begin
    ctrl.ins   = accept && (kind_i == KindInsert) && !full;
    ctrl.rem   = accept && (kind_i == KindRemove) && (count_q != '0);
    count_d    = count_q;
    status_d   = ST_OK;
    res_val_d  = '0;
    res_prio_d = '0;
    if (kind_i == KindInsert) begin
      if (full) begin
        status_d = ST_FULL;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else begin
      if (count_q == '0) begin
        status_d = ST_EMPTY;
      end else begin
        count_d    = count_q - CntW'(1);
        res_val_d  = cell_val[0];
        res_prio_d = cell_prio[0];
      end
    end
  end

  // Row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                   lkeep;
    logic signed [ValW-1:0] lval, rval;
    logic [PrioW-1:0]       lprio, rprio;

    if (i == 0) begin : g_first
      assign lkeep = 1'b1;
      assign lval  = item_value_i;
      assign lprio = prio_in_i;
    end else begin : g_inner
      assign lkeep = cell_keep[i-1];
      assign lval  = cell_val[i-1];
      assign lprio = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rval  = cell_val[i];
      assign rprio = cell_prio[i];
    end else begin : g_mid
      assign rval  = cell_val[i+1];
      assign rprio = cell_prio[i+1];
    end

    sapq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occ_i        (CntW'(i) < count_q),
      .new_val_i    (item_value_i),
      .new_prio_i   (prio_in_i),
      .left_keep_i  (lkeep),
      .left_val_i   (lval),
      .left_prio_i  (lprio),
      .right_val_i  (rval),
      .right_prio_i (rprio),
      .keep_o       (cell_keep[i]),
      .val_o        (cell_val[i]),
      .prio_o       (cell_prio[i])
    );
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= CapReset;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        capacity_q <= cfg_data_i;
      end
      if (accept) begin
        count_q <= count_d;
      end
      res_valid_q <= accept;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q   <= status_d;
      res_val_q  <= res_val_d;
      res_prio_q <= res_prio_d;
    end
  end

  assign result_valid_o = res_valid_q;
  assign status_o       = status_q;
  assign out_value_o    = res_val_q;
  assign out_prio_o     = res_prio_q;
  assign fill_count_o   = count_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("fill count above depth");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept))
    else $error("result without command");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("insert did not grow the queue");

  a_front_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.rem |=> ((count_q == '0) || (out_prio_o >= cell_prio[0])))
    else $error("removed entry below new front");

  a_refused_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (kind_i == KindInsert) && full) |=>
      ((status_o == ST_FULL) && (count_q == $past(count_q))))
    else $error("refused insert changed the queue");
`endif

endmodule
